/* design/nms_pkg.sv */
package nms_pkg;

  // Default build-time sizes
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] FRAME_RESET = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS = 2'd0,
    REG_FRAME_COLS = 2'd1
  } nms_reg_t;

  // Neighbours in a 3x3 window
  localparam int NEIGHBOURS = 8;

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

  // Which decisions one pixel releases, in delivery order a, b, c, d:
  //   a: centre of window, b: right column (row end),
  //   c: bottom row (last row), d: bottom right (last pixel of frame)
  typedef struct packed {
    logic emit_a;
    logic emit_b;
    logic emit_c;
    logic emit_d;
  } nms_emit_t;

  localparam int EMIT_W = $bits(nms_emit_t);

  // Index width for a dimension, at least one bit
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* design/nms_pix_if.sv */
interface nms_pix_if #(
  parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

/* design/nms_res_if.sv */
interface nms_res_if #(
  parameter int ROW_W      = 10,
  parameter int COL_W      = 10,
  parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF,
  parameter int CNT_W      = 21
);
  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      pixel_row;
  logic [COL_W-1:0]      pixel_col;
  logic [PIXEL_BITS-1:0] center_value;
  logic                  is_peak;
  logic [CNT_W-1:0]      peak_total;
  logic                  frame_done;

  modport source (output valid, output pixel_row, output pixel_col, output center_value,
                  output is_peak, output peak_total, output frame_done, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, input center_value,
                  input is_peak, input peak_total, input frame_done, output ready);
endinterface

/* design/nms_queue.sv */
module nms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nms_pkg::Q_DEPTH,
  parameter int LVL_W = nms_pkg::Q_LVL_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             head_valid,
  output logic [LVL_W-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign dout       = slots[rd_ptr];
  assign head_valid = (level != '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* design/nms_front.sv */
module nms_front #(
  parameter int MAX_COLS   = nms_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = nms_pkg::MAX_ROWS_DEF,
  parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF,
  parameter int ROW_W      = 10,
  parameter int COL_W      = 10,
  parameter int JOB_W      = 9 * 16 + 24
) (
  input  logic                         clk,
  input  logic                         rst,
  nms_pix_if.sink                      pix_in,
  input  logic                         cfg_we,
  input  logic [nms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nms_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         restart,
  input  logic [nms_pkg::Q_LVL_W-1:0]  q_level,
  output logic                         push,
  output logic [JOB_W-1:0]             job
);

  localparam int PB  = PIXEL_BITS;
  localparam int RWW = (ROW_W + 1 > nms_pkg::CFG_W) ? ROW_W + 1 : nms_pkg::CFG_W;
  localparam int CWW = (COL_W + 1 > nms_pkg::CFG_W) ? COL_W + 1 : nms_pkg::CFG_W;

  logic [nms_pkg::CFG_W-1:0] frame_rows;
  logic [nms_pkg::CFG_W-1:0] frame_cols;
  logic [RWW-1:0]            rows_ext;
  logic [CWW-1:0]            cols_ext;
  logic [ROW_W-1:0]          rows_last;
  logic [COL_W-1:0]          cols_last;

  logic [ROW_W-1:0]          row_counter;
  logic [COL_W-1:0]          col_counter;
  logic                      accept;
  logic                      last_row;
  logic                      last_col;
  nms_pkg::nms_emit_t        emit_next;

  // Stage one: pixel whose line-buffer read is in flight
  logic                      s1_valid;
  logic [PB-1:0]             s1_pix;
  logic [ROW_W-1:0]          s1_row;
  logic [COL_W-1:0]          s1_col;
  nms_pkg::nms_emit_t        s1_emit;

  // Line buffers, older and newer row side by side
  logic [2*PB-1:0]           line_mem [MAX_COLS];
  logic [2*PB-1:0]           line_rd;
  logic                      byp;
  logic [2*PB-1:0]           byp_data;
  logic [2*PB-1:0]           line_eff;
  logic [2*PB-1:0]           line_wr;

  logic [PB-1:0]             win      [3][3];
  logic [PB-1:0]             win_next [3][3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= nms_pkg::FRAME_RESET;
      frame_cols <= nms_pkg::FRAME_RESET;
    end else if (cfg_we) begin
      case (nms_pkg::nms_reg_t'(cfg_index))
        nms_pkg::REG_FRAME_ROWS: frame_rows <= cfg_data;
        nms_pkg::REG_FRAME_COLS: frame_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, above the maximum acts as the maximum
  assign rows_ext = RWW'(frame_rows);
  assign cols_ext = CWW'(frame_cols);

  always_comb begin
    if (rows_ext == '0) begin
      rows_last = '0;
    end else if (rows_ext > RWW'(MAX_ROWS)) begin
      rows_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_W'(rows_ext - 1'b1);
    end
    if (cols_ext == '0) begin
      cols_last = '0;
    end else if (cols_ext > CWW'(MAX_COLS)) begin
      cols_last = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last = COL_W'(cols_ext - 1'b1);
    end
  end

  // Accept while the queue has room for everything in flight
  assign pix_in.ready = (q_level + nms_pkg::Q_LVL_W'(s1_valid)) <
                        nms_pkg::Q_LVL_W'(nms_pkg::Q_DEPTH);
  assign accept = pix_in.valid && pix_in.ready;

  // Classify the pixel by the decisions it releases
  assign last_row = (row_counter == rows_last);
  assign last_col = (col_counter == cols_last);

  always_comb begin
    emit_next.emit_a = (row_counter != '0) && (col_counter != '0);
    emit_next.emit_b = (row_counter != '0) && last_col;
    emit_next.emit_c = last_row && (col_counter != '0);
    emit_next.emit_d = last_row && last_col;
  end

  // Raster position and stage-one control
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (restart) begin
        row_counter <= '0;
        col_counter <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_counter <= '0;
          row_counter <= last_row ? '0 : row_counter + 1'b1;
        end else begin
          col_counter <= col_counter + 1'b1;
        end
      end
    end
  end

  // Stage-one payload and line-buffer bypass (single column frames)
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pix_in.pixel_value;
      s1_row   <= row_counter;
      s1_col   <= col_counter;
      s1_emit  <= emit_next;
      byp      <= s1_valid && (s1_col == col_counter);
      byp_data <= line_wr;
    end
  end

  assign line_eff = byp ? byp_data : line_rd;
  assign line_wr  = {line_eff[PB-1:0], s1_pix};

  // Line buffer memory: read on accept, write back from stage one
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= line_wr;
    end
    if (accept) begin
      line_rd <= line_mem[col_counter];
    end
  end

  // Window shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = line_eff[2*PB-1:PB];
    win_next[1][2] = line_eff[PB-1:0];
    win_next[2][2] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // Job to the back end: window, position, decision set
  assign push = s1_valid && (s1_emit != '0);

  always_comb begin
    job[nms_pkg::EMIT_W-1:0]                                 = s1_emit;
    job[nms_pkg::EMIT_W +: COL_W]                            = s1_col;
    job[nms_pkg::EMIT_W + COL_W +: ROW_W]                    = s1_row;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        job[nms_pkg::EMIT_W + COL_W + ROW_W + (r * 3 + c) * PB +: PB] = win_next[r][c];
      end
    end
  end

endmodule

/* design/nms_back.sv */
module nms_back #(
  parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF,
  parameter int ROW_W      = 10,
  parameter int COL_W      = 10,
  parameter int CNT_W      = 21,
  parameter int JOB_W      = 9 * 16 + 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             head_valid,
  input  logic [JOB_W-1:0] head,
  output logic             pop,
  nms_res_if.source        res_out
);

  localparam int PB    = PIXEL_BITS;
  localparam int WIN_O = nms_pkg::EMIT_W + COL_W + ROW_W;

  nms_pkg::nms_emit_t emit;
  nms_pkg::nms_emit_t done;
  nms_pkg::nms_emit_t rem;
  nms_pkg::nms_emit_t sel;
  logic [ROW_W-1:0]   job_row;
  logic [COL_W-1:0]   job_col;
  logic [PB-1:0]      w   [3][3];
  logic [PB-1:0]      rw  [3][3];
  logic [PB-1:0]      nb  [3][3];
  logic               cr2;
  logic               cc2;
  logic [ROW_W-1:0]   pr;
  logic [COL_W-1:0]   pc;
  logic [2:0]         row_ok;
  logic [2:0]         col_ok;
  logic [nms_pkg::NEIGHBOURS-1:0] passed;
  logic               peak;
  logic               load;
  logic               last_of_job;
  logic [CNT_W-1:0]   peak_counter;
  logic [CNT_W-1:0]   cnt_new;

  logic               out_valid;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic [PB-1:0]      out_value;
  logic               out_peak;
  logic [CNT_W-1:0]   out_total;
  logic               out_done;

  // Unpack the job at the queue head
  always_comb begin
    emit    = nms_pkg::nms_emit_t'(head[nms_pkg::EMIT_W-1:0]);
    job_col = head[nms_pkg::EMIT_W +: COL_W];
    job_row = head[nms_pkg::EMIT_W + COL_W +: ROW_W];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        w[r][c] = head[WIN_O + (r * 3 + c) * PB +: PB];
      end
    end
  end

  // Next decision of this job, in delivery order
  always_comb begin
    rem        = emit & ~done;
    sel.emit_a = rem.emit_a;
    sel.emit_b = rem.emit_b && !rem.emit_a;
    sel.emit_c = rem.emit_c && !rem.emit_a && !rem.emit_b;
    sel.emit_d = rem.emit_d && !rem.emit_a && !rem.emit_b && !rem.emit_c;
  end

  assign cr2 = sel.emit_c || sel.emit_d;
  assign cc2 = sel.emit_b || sel.emit_d;
  assign pr  = cr2 ? job_row : job_row - 1'b1;
  assign pc  = cc2 ? job_col : job_col - 1'b1;

  // Recentre the window on the pixel being decided
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rw[0][c] = cr2 ? w[1][c] : w[0][c];
      rw[1][c] = cr2 ? w[2][c] : w[1][c];
      rw[2][c] = w[2][c];
    end
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = cc2 ? rw[r][1] : rw[r][0];
      nb[r][1] = cc2 ? rw[r][2] : rw[r][1];
      nb[r][2] = rw[r][2];
    end
  end

  // Neighbours outside the frame pass
  assign row_ok = {!cr2, 1'b1, pr != '0};
  assign col_ok = {!cc2, 1'b1, pc != '0};

  always_comb begin
    passed[0] = !(row_ok[0] && col_ok[0]) || (nb[1][1] > nb[0][0]);
    passed[1] = !(row_ok[0] && col_ok[1]) || (nb[1][1] > nb[0][1]);
    passed[2] = !(row_ok[0] && col_ok[2]) || (nb[1][1] > nb[0][2]);
    passed[3] = !(row_ok[1] && col_ok[0]) || (nb[1][1] > nb[1][0]);
    passed[4] = !(row_ok[1] && col_ok[2]) || (nb[1][1] > nb[1][2]);
    passed[5] = !(row_ok[2] && col_ok[0]) || (nb[1][1] > nb[2][0]);
    passed[6] = !(row_ok[2] && col_ok[1]) || (nb[1][1] > nb[2][1]);
    passed[7] = !(row_ok[2] && col_ok[2]) || (nb[1][1] > nb[2][2]);
  end

  assign peak        = &passed;
  assign cnt_new     = peak_counter + CNT_W'(peak);
  assign load        = head_valid && (!out_valid || res_out.ready);
  assign last_of_job = ((rem & ~sel) == '0);
  assign pop         = load && last_of_job;

  // Output register control, decision progress and peak count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      done         <= '0;
      peak_counter <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        done <= last_of_job ? '0 : (done | sel);
      end
      if (restart) begin
        peak_counter <= '0;
      end else if (load) begin
        peak_counter <= sel.emit_d ? '0 : cnt_new;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_row   <= pr;
      out_col   <= pc;
      out_value <= nb[1][1];
      out_peak  <= peak;
      out_total <= cnt_new;
      out_done  <= sel.emit_d;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.pixel_row    = out_row;
  assign res_out.pixel_col    = out_col;
  assign res_out.center_value = out_value;
  assign res_out.is_peak      = out_peak;
  assign res_out.peak_total   = out_total;
  assign res_out.frame_done   = out_done;

endmodule

/* design/strict_3x3_local_maximum_detect_top.sv */
// Strict 3x3 local maximum detector.
// pix_in takes one pixel per transfer in raster order; res_out gives one
// decision per transfer: row, column, value, peak flag, running peak count
// of the frame and a flag on the frame's final decision. A pixel is a peak
// when it is strictly above every neighbour inside the frame.
// Frame size is set through cfg_we/cfg_index/cfg_data (index 0 rows,
// index 1 columns); a write restarts the frame and clears the peak count.
// Throughput: one pixel per cycle while decisions keep pace; a pixel releases
// zero to four decisions, one per frame pixel on average, and res_out gives
// one per cycle while ready. Along the last row each pixel after the first
// releases two, so pix_in slows to the pace of res_out; the last up to four.
// A decision reaches res_out through the line buffer read and stage one, the
// window update into the job queue and the output register; further decisions
// of the same pixel follow one per cycle while res_out is ready. The
// four-entry job queue absorbs the bursts at row ends and pix_in.ready
// drops when it cannot take another job.
// When res_out stalls, the output register holds, the queue fills and
// pix_in.ready falls; nothing is lost.
// Reset clears the window, position, peak count and queue and sets both
// sizes to 1024; line buffer contents are not cleared.
module strict_3x3_local_maximum_detect_top #(
  parameter int MAX_COLS   = nms_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = nms_pkg::MAX_ROWS_DEF,
  parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  nms_pix_if.sink                       pix_in,
  nms_res_if.source                     res_out,
  input  logic                          cfg_we,
  input  logic [nms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nms_pkg::CFG_W-1:0]     cfg_data
);

  localparam int ROW_W = nms_pkg::idx_bits(MAX_ROWS);
  localparam int COL_W = nms_pkg::idx_bits(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int JOB_W = 9 * PIXEL_BITS + ROW_W + COL_W + nms_pkg::EMIT_W;

  logic                        restart;
  logic                        push;
  logic [JOB_W-1:0]            job;
  logic                        pop;
  logic [JOB_W-1:0]            head;
  logic                        head_valid;
  logic [nms_pkg::Q_LVL_W-1:0] q_level;

  // A size write restarts the frame
  assign restart = cfg_we && ((cfg_index == nms_pkg::REG_FRAME_ROWS) ||
                              (cfg_index == nms_pkg::REG_FRAME_COLS));

  nms_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS),
    .ROW_W      (ROW_W),
    .COL_W      (COL_W),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .q_level   (q_level),
    .push      (push),
    .job       (job)
  );

  nms_queue #(
    .WIDTH (JOB_W),
    .DEPTH (nms_pkg::Q_DEPTH),
    .LVL_W (nms_pkg::Q_LVL_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (job),
    .pop        (pop),
    .dout       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  nms_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .ROW_W      (ROW_W),
    .COL_W      (COL_W),
    .CNT_W      (CNT_W),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_out    (res_out)
  );

endmodule

/* design/nms_chk.sv */
module nms_chk #(
  parameter int PIXEL_BITS = nms_pkg::PIXEL_BITS_DEF,
  parameter int ROW_W      = 10,
  parameter int COL_W      = 10,
  parameter int CNT_W      = 21
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [ROW_W-1:0]      pixel_row,
  input logic [COL_W-1:0]      pixel_col,
  input logic [PIXEL_BITS-1:0] center_value,
  input logic                  is_peak,
  input logic [CNT_W-1:0]      peak_total,
  input logic                  frame_done
);

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pixel_row) && $stable(pixel_col) &&
      $stable(center_value) && $stable(is_peak) && $stable(peak_total) &&
      $stable(frame_done))
    else $error("stalled result changed");

  // A peak is counted in its own total
  a_peak_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_peak |-> peak_total != '0)
    else $error("peak with zero running total");

endmodule

bind strict_3x3_local_maximum_detect_top nms_chk #(
  .PIXEL_BITS (PIXEL_BITS),
  .ROW_W      (ROW_W),
  .COL_W      (COL_W),
  .CNT_W      (CNT_W)
) u_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_out.valid),
  .res_ready    (res_out.ready),
  .pixel_row    (res_out.pixel_row),
  .pixel_col    (res_out.pixel_col),
  .center_value (res_out.center_value),
  .is_peak      (res_out.is_peak),
  .peak_total   (res_out.peak_total),
  .frame_done   (res_out.frame_done)
);
